// ===== rtl/cpu_exception_and_perf_monitor_defines.svh =====
// Assertion macros for the exception and performance monitor block.
`ifndef CPU_EXCEPTION_AND_PERF_MONITOR_DEFINES_SVH
`define CPU_EXCEPTION_AND_PERF_MONITOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check on every clock edge outside reset.
`define CPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check on every clock edge, reset included.
`define CPM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define CPM_ASSERT(lbl, prop, msg)
`define CPM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/cpumon_pkg.sv =====
// Types, constants and tables shared by the exception and performance monitor.
package cpumon_pkg;

    localparam int NUM_EXC   = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [1:0] {
        ACT_RAISE     = 2'd0,
        ACT_PERF      = 2'd1,
        ACT_CHECK_ALL = 2'd2,
        ACT_CHECK_EXT = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PMC1_SEL = 3'd0,
        CFG_PMC2_SEL = 3'd1,
        CFG_PMC3_SEL = 3'd2,
        CFG_PMC4_SEL = 3'd3,
        CFG_PMC1_IE  = 3'd4,
        CFG_PMCN_IE  = 3'd5
    } t_cfg_idx;

    // Exception bit positions in the pending register.
    localparam int EXC_ISI     = 0;
    localparam int EXC_PROGRAM = 1;
    localparam int EXC_PERFMON = 7;
    localparam int EXC_EE_LO   = 6;

    // Event select codes.
    localparam logic [6:0] SEL_CYCLES = 7'd1;
    localparam logic [6:0] SEL_EVENTS = 7'd11;

    localparam logic [31:0] SRR1_KEEP = 32'h87C0_FFFF;
    localparam logic [31:0] MSR_CLEAR = 32'h0004_EF36;
    localparam int          MSR_EE_BIT = 15;
    localparam int          MSR_ILE_BIT = 16;
    localparam logic [31:0] ISI_FLAG  = 32'h4000_0000;
    localparam logic [31:0] TRAP_FLAG = 32'h0002_0000;

    // Entry addresses, index 0 (ISI) in the low slot.
    localparam logic [NUM_EXC-1:0][11:0] EXC_VEC = {
        12'h900, 12'hF00, 12'h500, 12'h600, 12'h300,
        12'h800, 12'hC00, 12'h700, 12'h400
    };
    // Set where SRR0 takes the next PC rather than the current PC.
    localparam logic [NUM_EXC-1:0] USE_NPC = 9'b1_1100_0101;

    typedef struct packed {
        t_action     action;
        logic [8:0]  raise_bits;
        logic [31:0] cycle_count;
        logic [31:0] load_store_count;
        logic [31:0] fp_inst_count;
        logic [31:0] current_pc;
        logic [31:0] next_pc;
        logic [31:0] machine_state;
    } t_in;

    typedef struct packed {
        logic        taken;
        logic [11:0] vector;
        logic [31:0] saved_pc;
        logic [31:0] saved_state;
        logic [31:0] new_state;
        logic [8:0]  pending_out;
        logic [31:0] counter1;
        logic [31:0] counter2;
        logic [31:0] counter3;
        logic [31:0] counter4;
    } t_out;

    typedef struct packed {
        logic [6:0] pmc1_select;
        logic [5:0] pmc2_select;
        logic [4:0] pmc3_select;
        logic [4:0] pmc4_select;
        logic       pmc1_int_enable;
        logic       pmcn_int_enable;
    } t_cfg;

    typedef struct packed {
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] c3;
        logic [31:0] c4;
    } t_counters;

    typedef struct packed {
        logic        taken;
        logic [11:0] vector;
        logic [31:0] saved_pc;
        logic [31:0] saved_state;
        logic [31:0] new_state;
        logic [8:0]  pending;
    } t_exc_res;

endpackage

// ===== rtl/cpu_exception_and_perf_monitor.sv =====
// Top level: exception vectoring and performance monitor with a two-register pipeline.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_data  (t_in)
//  out     | output    | o_out_valid/ i_out_ready| o_out_data (t_out)
//  cfg     | input     | i_cfg_we (no wait)      | i_cfg_index, i_cfg_data
//
//  One item per cycle sustained while the output does not stall.
//  The item sits in the input register, the exception and counter logic works on it
//  there, and the result register catches the answer while the state registers update.
//  Reset clears pending bits, counters, config and both valid flags.
//  A stalled output holds the result register and then the input register; the input
//  register still refills in the cycle the result is taken.
`include "cpu_exception_and_perf_monitor_defines.svh"
module cpu_exception_and_perf_monitor (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  cpumon_pkg::t_in                       i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output cpumon_pkg::t_out                      o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [cpumon_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cpumon_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    cpumon_pkg::t_cfg      r_cfg;
    cpumon_pkg::t_in       r_in;
    logic                  r_in_valid;
    cpumon_pkg::t_out      r_out;
    logic                  r_out_valid;
    logic                  adv;
    logic                  perf_hit;
    cpumon_pkg::t_counters cnt;
    cpumon_pkg::t_exc_res  exc;
    logic                  raise_adv;
    logic                  raise_kept;

    // Advance the held item into the result register when that slot is free or draining.
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    // Configuration registers; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (cpumon_pkg::t_cfg_idx'(i_cfg_index))
                cpumon_pkg::CFG_PMC1_SEL: r_cfg.pmc1_select     <= i_cfg_data[6:0];
                cpumon_pkg::CFG_PMC2_SEL: r_cfg.pmc2_select     <= i_cfg_data[5:0];
                cpumon_pkg::CFG_PMC3_SEL: r_cfg.pmc3_select     <= i_cfg_data[4:0];
                cpumon_pkg::CFG_PMC4_SEL: r_cfg.pmc4_select     <= i_cfg_data[4:0];
                cpumon_pkg::CFG_PMC1_IE:  r_cfg.pmc1_int_enable <= i_cfg_data[0];
                cpumon_pkg::CFG_PMCN_IE:  r_cfg.pmcn_int_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register: capture on accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    cpumon_perf u_perf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_in    (r_in),
        .i_cfg   (r_cfg),
        .o_cnt   (cnt),
        .o_hit   (perf_hit)
    );

    cpumon_exc u_exc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_in       (r_in),
        .i_perf_hit (perf_hit),
        .o_res      (exc)
    );

    // Result register: valid drops once taken unless a new item advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.taken       <= exc.taken;
            r_out.vector      <= exc.vector;
            r_out.saved_pc    <= exc.saved_pc;
            r_out.saved_state <= exc.saved_state;
            r_out.new_state   <= exc.new_state;
            r_out.pending_out <= exc.pending;
            r_out.counter1    <= cnt.c1;
            r_out.counter2    <= cnt.c2;
            r_out.counter3    <= cnt.c3;
            r_out.counter4    <= cnt.c4;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A raise that advances must leave all of its bits in the pending set it reports.
    assign raise_adv  = adv && (r_in.action == cpumon_pkg::ACT_RAISE);
    assign raise_kept = ((exc.pending & r_in.raise_bits) == r_in.raise_bits);

    `CPM_ASSERT_ALWAYS(a_reset_empties_out, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `CPM_ASSERT(a_ready_when_out_empty, !r_out_valid |-> o_in_ready, "input stalled, output empty")
    `CPM_ASSERT(a_raise_lands, raise_adv |-> raise_kept, "raised bits missing from pending")

endmodule

// ===== rtl/cpumon_perf.sv =====
// Performance counters: four wrapping counters and the overflow-bit check.
module cpumon_perf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  cpumon_pkg::t_in       i_in,
    input  cpumon_pkg::t_cfg      i_cfg,
    output cpumon_pkg::t_counters o_cnt,
    output logic                  o_hit
);

    cpumon_pkg::t_counters r_cnt;
    cpumon_pkg::t_counters n_cnt;
    logic                  perf_act;

    assign perf_act = (i_in.action == cpumon_pkg::ACT_PERF);

    always_comb begin
        n_cnt = r_cnt;
        if (perf_act) begin
            if (i_cfg.pmc1_select == cpumon_pkg::SEL_CYCLES) begin
                n_cnt.c1 = r_cnt.c1 + i_in.cycle_count;
            end
            if (i_cfg.pmc2_select == cpumon_pkg::SEL_CYCLES[5:0]) begin
                n_cnt.c2 = r_cnt.c2 + i_in.cycle_count;
            end else if (i_cfg.pmc2_select == cpumon_pkg::SEL_EVENTS[5:0]) begin
                n_cnt.c2 = r_cnt.c2 + i_in.load_store_count;
            end
            if (i_cfg.pmc3_select == cpumon_pkg::SEL_CYCLES[4:0]) begin
                n_cnt.c3 = r_cnt.c3 + i_in.cycle_count;
            end else if (i_cfg.pmc3_select == cpumon_pkg::SEL_EVENTS[4:0]) begin
                n_cnt.c3 = r_cnt.c3 + i_in.fp_inst_count;
            end
            if (i_cfg.pmc4_select == cpumon_pkg::SEL_CYCLES[4:0]) begin
                n_cnt.c4 = r_cnt.c4 + i_in.cycle_count;
            end
        end
    end

    // Overflow check uses the counts after this update.
    assign o_hit = perf_act &&
                   ((i_cfg.pmc1_int_enable && n_cnt.c1[31]) ||
                    (i_cfg.pmcn_int_enable && (n_cnt.c2[31] | n_cnt.c3[31] | n_cnt.c4[31])));
    assign o_cnt = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_adv) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/cpumon_exc.sv =====
// Pending-exception register, priority select and exception entry values.
module cpumon_exc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  cpumon_pkg::t_in      i_in,
    input  logic                 i_perf_hit,
    output cpumon_pkg::t_exc_res o_res
);

    localparam int N = cpumon_pkg::NUM_EXC;

    logic [N-1:0] r_pending;
    logic [N-1:0] n_pending;
    logic [N-1:0] elig;
    logic [N-1:0] sel_oh;
    logic         check;
    logic         ee;
    logic [11:0]  vec;
    logic         use_npc;
    logic [31:0]  msr;

    assign msr   = i_in.machine_state;
    assign ee    = msr[cpumon_pkg::MSR_EE_BIT];
    assign check = (i_in.action == cpumon_pkg::ACT_CHECK_ALL) ||
                   (i_in.action == cpumon_pkg::ACT_CHECK_EXT);

    always_comb begin
        elig = '0;
        if (i_in.action == cpumon_pkg::ACT_CHECK_ALL) begin
            elig[cpumon_pkg::EXC_EE_LO-1:0] = r_pending[cpumon_pkg::EXC_EE_LO-1:0];
        end
        if (check && ee) begin
            elig[N-1:cpumon_pkg::EXC_EE_LO] = r_pending[N-1:cpumon_pkg::EXC_EE_LO];
        end
    end

    // Lowest set bit has the highest priority.
    assign sel_oh = elig & (~elig + {{(N-1){1'b0}}, 1'b1});

    always_comb begin
        vec = '0;
        for (int i = 0; i < N; i++) begin
            if (sel_oh[i]) begin
                vec = vec | cpumon_pkg::EXC_VEC[i];
            end
        end
    end

    assign use_npc = |(sel_oh & cpumon_pkg::USE_NPC);

    always_comb begin
        n_pending = r_pending;
        case (i_in.action)
            cpumon_pkg::ACT_RAISE: n_pending = r_pending | i_in.raise_bits;
            cpumon_pkg::ACT_PERF: begin
                if (i_perf_hit) begin
                    n_pending[cpumon_pkg::EXC_PERFMON] = 1'b1;
                end
            end
            default: n_pending = r_pending & ~sel_oh;
        endcase
    end

    always_comb begin
        o_res.taken       = |sel_oh;
        o_res.vector      = vec;
        o_res.saved_pc    = '0;
        o_res.saved_state = '0;
        o_res.new_state   = msr;
        o_res.pending     = n_pending;
        if (|sel_oh) begin
            o_res.saved_pc    = use_npc ? i_in.next_pc : i_in.current_pc;
            o_res.saved_state = (msr & cpumon_pkg::SRR1_KEEP)
                              | (sel_oh[cpumon_pkg::EXC_ISI] ? cpumon_pkg::ISI_FLAG : 32'h0)
                              | (sel_oh[cpumon_pkg::EXC_PROGRAM] ? cpumon_pkg::TRAP_FLAG : 32'h0);
            o_res.new_state   = {msr[31:1], msr[0] | msr[cpumon_pkg::MSR_ILE_BIT]}
                              & ~cpumon_pkg::MSR_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (i_adv) begin
            r_pending <= n_pending;
        end
    end

endmodule
